// ===== hw/rtl/sofdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sofdf_pkg
// Shared types and constants for the start-of-frame / length / XOR deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sofdf_pkg;

  localparam int unsigned ByteW = 8;

  // Start-of-frame byte value after reset.
  localparam logic [ByteW-1:0] SofReset = 8'hfe;

  // Kind of word passed downstream.
  typedef enum logic [1:0] {
    KIND_CMD0    = 2'd0,
    KIND_CMD_ID  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_CHECK   = 2'd3
  } item_kind_e;

  // One result word as produced by the frame state step.
  typedef struct packed {
    logic             valid;
    item_kind_e       kind;
    logic [ByteW-1:0] value;
    logic [ByteW-1:0] index;
    logic [ByteW-1:0] length;
    logic             frame_end;
    logic             check_ok;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sofdf_if.sv =====
// ----------------------------------------------------------------------------
// sofdf_rx_if / sofdf_res_if
// Valid/ready channels carrying received bytes in and deframed words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sofdf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sofdf_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] byte_value;
  logic [7:0] payload_index;
  logic [7:0] payload_length;
  logic       frame_end;
  logic       checksum_ok;

  modport source (
    output valid, output item_kind, output byte_value, output payload_index,
    output payload_length, output frame_end, output checksum_ok, input ready
  );
  modport sink (
    input valid, input item_kind, input byte_value, input payload_index,
    input payload_length, input frame_end, input checksum_ok, output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/sofdf_core.sv =====
// ----------------------------------------------------------------------------
// sofdf_core
// Frame state: phase, running XOR, announced length and payload position.
// Computes the result word for one byte and advances when step_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sofdf_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [sofdf_pkg::ByteW-1:0] byte_i,
  input  wire logic [sofdf_pkg::ByteW-1:0] sof_i,
  output sofdf_pkg::res_t                  res_o
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_CMD0    = 3'd2,
    PH_CMD1    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [sofdf_pkg::ByteW-1:0]   xor_q, xor_d;
  logic [sofdf_pkg::ByteW-1:0]   len_q, len_d;
  logic [sofdf_pkg::ByteW-1:0]   pos_q, pos_d;
  logic [sofdf_pkg::ByteW-1:0]   pos_inc;

  assign pos_inc = pos_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    xor_d   = xor_q;
    len_d   = len_q;
    pos_d   = pos_q;

    res_o           = '0;
    res_o.kind      = sofdf_pkg::KIND_CMD0;
    res_o.length    = len_q;

    case (phase_q)
      PH_LEN: begin
        len_d   = byte_i;
        xor_d   = byte_i;
        pos_d   = '0;
        phase_d = PH_CMD0;
      end
      PH_CMD0: begin
        xor_d       = xor_q ^ byte_i;
        res_o.valid = 1'b1;
        res_o.kind  = sofdf_pkg::KIND_CMD0;
        res_o.value = byte_i;
        phase_d     = PH_CMD1;
      end
      PH_CMD1: begin
        xor_d       = xor_q ^ byte_i;
        res_o.valid = 1'b1;
        res_o.kind  = sofdf_pkg::KIND_CMD_ID;
        res_o.value = byte_i;
        phase_d     = (len_q == '0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        xor_d       = xor_q ^ byte_i;
        res_o.valid = 1'b1;
        res_o.kind  = sofdf_pkg::KIND_PAYLOAD;
        res_o.value = byte_i;
        res_o.index = pos_q;
        pos_d       = pos_inc;
        if (pos_inc == len_q) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        res_o.valid     = 1'b1;
        res_o.kind      = sofdf_pkg::KIND_CHECK;
        res_o.frame_end = 1'b1;
        res_o.check_ok  = (byte_i == xor_q);
        phase_d         = PH_HUNT;
      end
      default: begin
        // Hunting: everything but the start byte is dropped.
        phase_d = PH_HUNT;
        if (byte_i == sof_i) begin
          xor_d   = '0;
          phase_d = PH_LEN;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      xor_q   <= '0;
      len_q   <= '0;
      pos_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      xor_q   <= xor_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sof_length_xor_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// sof_length_xor_frame_deframer
// Hunts for a start byte, then reads length, two command bytes, payload and
// an XOR check byte; passes command and payload bytes on and closes each
// frame with a check result word.
// ----------------------------------------------------------------------------
//
//   Channel    Dir   Handshake      Word
//   rx_i       in    valid/ready    rx_byte
//   res_o      out   valid/ready    item_kind, byte_value, payload_index,
//                                   payload_length, frame_end, checksum_ok
//   sof_byte   in    write enable   sof_byte_i (no read-back)
//
// One received byte is taken every cycle while the step is not waiting. An
// accepted byte is held in an input register; when the frame state steps,
// any result word is loaded into the output register and offered from there.
// Start and length bytes, and bytes dropped while hunting, produce no word.
// The step waits only while the output register is full and not being
// taken; the input register then holds and rx_i.ready falls. Reset returns
// to hunting with the start byte at 0xfe.
// ----------------------------------------------------------------------------
`default_nettype none

module sof_length_xor_frame_deframer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        sof_byte_we_i,
  input  wire logic [sofdf_pkg::ByteW-1:0] sof_byte_i,
  sofdf_rx_if.sink                         rx_i,
  sofdf_res_if.source                      res_o
);

  // Start-of-frame register. The user must write it only while the block is idle; the block does not enforce this.
  logic [sofdf_pkg::ByteW-1:0] sof_q;

  // Input register holding one accepted byte.
  logic                        in_valid_q;
  logic [sofdf_pkg::ByteW-1:0] in_byte_q;

  // Output register holding one finished word.
  logic            out_valid_q;
  sofdf_pkg::res_t out_q;

  sofdf_pkg::res_t step_res;
  logic            out_free;
  logic            step;
  logic            rx_fire;

  // The output register can take a new word when empty or being drained.
  assign out_free = !out_valid_q || res_o.ready;
  assign step     = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || step;
  assign rx_fire  = rx_i.valid && rx_i.ready;

  sofdf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .sof_i  (sof_q),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof_q <= sofdf_pkg::SofReset;
    end else if (sof_byte_we_i) begin
      sof_q <= sof_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && step_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && step_res.valid) begin
      out_q <= step_res;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.item_kind      = out_q.kind;
  assign res_o.byte_value     = out_q.value;
  assign res_o.payload_index  = out_q.index;
  assign res_o.payload_length = out_q.length;
  assign res_o.frame_end      = out_q.frame_end;
  assign res_o.checksum_ok    = out_q.check_ok;

endmodule

`default_nettype wire

// ===== test/tb_sof_length_xor_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_sof_length_xor_frame_deframer
// Self-checking testbench for the start-of-frame / length / XOR deframer.
// Received bytes are pushed through the rx channel while a cycle-free model
// of the frame state tracks every accepted byte and queues the words it
// should produce. Each word taken from the result channel is compared with
// the oldest queued word. Directed frames cover hunting, zero length,
// corrupted checks, start bytes inside a frame and a start byte change in
// the middle of a frame. Random traffic with gaps, stalls and one long
// output hold-off follows under several start byte settings.
// ----------------------------------------------------------------------------

module tb_sof_length_xor_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import sofdf_pkg::*;

  // A word leaves the block from the output register, after its byte has passed the input register.
  localparam int WordLatency = 2;
  // Cycles without any handshake before the run is declared hung. The
  // longest legal quiet stretch is the output hold-off below.
  localparam int StallLimit = 5000;
  localparam int HoldOffCycles = 300;
  localparam int MaxReports = 10;

  // Frame state of the prediction, one step per accepted byte.
  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LENGTH,
    ST_CMD0,
    ST_CMD_ID,
    ST_PAYLOAD,
    ST_CHECK
  } frame_state_e;

  // How the generator fills command and payload bytes of a frame.
  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_SOF,
    FILL_EXTREME
  } fill_e;

  typedef struct packed {
    item_kind_e       kind;
    logic [ByteW-1:0] value;
    logic [ByteW-1:0] index;
    logic [ByteW-1:0] length;
    logic             frame_end;
    logic             check_ok;
  } deframed_word_t;

  logic             clk_i;
  logic             rst_ni;
  logic             sof_byte_we_i;
  logic [ByteW-1:0] sof_byte_i;

  sofdf_rx_if  rx_if ();
  sofdf_res_if res_if ();

  sof_length_xor_frame_deframer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sof_byte_we_i (sof_byte_we_i),
    .sof_byte_i    (sof_byte_i),
    .rx_i          (rx_if),
    .res_o         (res_if)
  );

  // Shadow of the start byte register and of the frame state.
  logic [ByteW-1:0] cur_sof = SofReset;
  frame_state_e     fr_state = ST_HUNT;
  logic [ByteW-1:0] fr_xor = '0;
  logic [ByteW-1:0] fr_len = '0;
  logic [ByteW-1:0] fr_pos = '0;

  // Words still owed by the block, oldest first.
  deframed_word_t expected_words[$];

  int  fail_count = 0;
  int  framed_bytes = 0;
  // Random gaps on both channels are enabled by this flag.
  bit  idle_en = 1'b1;
  // Set by a test to make the receiver hold off for that many cycles.
  int  sink_hold_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction. One call per accepted byte; a word is queued whenever the
  // byte is a command byte, a payload byte or the closing check byte.
  // --------------------------------------------------------------------------
  function automatic void deframe_step(input logic [ByteW-1:0] b);
    deframed_word_t w;
    w = '{kind: KIND_CMD0, value: b, index: '0, length: fr_len,
          frame_end: 1'b0, check_ok: 1'b0};
    case (fr_state)
      ST_LENGTH: begin
        // The length byte opens the check sum and restarts the position.
        fr_len   = b;
        fr_xor   = b;
        fr_pos   = '0;
        fr_state = ST_CMD0;
      end
      ST_CMD0: begin
        fr_xor   = fr_xor ^ b;
        expected_words.push_back(w);
        fr_state = ST_CMD_ID;
      end
      ST_CMD_ID: begin
        fr_xor = fr_xor ^ b;
        w.kind = KIND_CMD_ID;
        expected_words.push_back(w);
        // With no payload the very next byte is the check byte.
        fr_state = (fr_len == '0) ? ST_CHECK : ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        fr_xor  = fr_xor ^ b;
        w.kind  = KIND_PAYLOAD;
        w.index = fr_pos;
        expected_words.push_back(w);
        fr_pos = fr_pos + 1'b1;
        if (fr_pos == fr_len) begin
          fr_state = ST_CHECK;
        end
      end
      ST_CHECK: begin
        w.kind      = KIND_CHECK;
        w.value     = '0;
        w.frame_end = 1'b1;
        w.check_ok  = (b == fr_xor);
        expected_words.push_back(w);
        fr_state = ST_HUNT;
      end
      default: begin
        // While hunting only the start byte matters; everything else is
        // dropped without a word.
        fr_state = ST_HUNT;
        if (b == cur_sof) begin
          fr_xor   = '0;
          fr_state = ST_LENGTH;
        end
      end
    endcase
  endfunction

  // Every byte taken by the block steps the prediction at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni && rx_if.valid && rx_if.ready) begin
      deframe_step(rx_if.rx_byte);
    end
  end

  // --------------------------------------------------------------------------
  // Result check. A word is taken at an edge where valid and ready are both
  // high, and must match the oldest word still expected.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_words
    deframed_word_t want;
    deframed_word_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.kind      = item_kind_e'(res_if.item_kind);
      got.value     = res_if.byte_value;
      got.index     = res_if.payload_index;
      got.length    = res_if.payload_length;
      got.frame_end = res_if.frame_end;
      got.check_ok  = res_if.checksum_ok;
      if (expected_words.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("%t unexpected word: kind=%0d val=%02h idx=%0d len=%0d end=%b ok=%b",
                   $realtime, got.kind, got.value, got.index, got.length,
                   got.frame_end, got.check_ok);
        end
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("%t word mismatch: exp kind=%0d val=%02h idx=%0d len=%0d end=%b ok=%b",
                     $realtime, want.kind, want.value, want.index, want.length,
                     want.frame_end, want.check_ok);
            $display("%t                got kind=%0d val=%02h idx=%0d len=%0d end=%b ok=%b",
                     $realtime, got.kind, got.value, got.index, got.length,
                     got.frame_end, got.check_ok);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. Ready is high by default, drops for random bursts while idling
  // is enabled, and drops for a long stretch when a test asks for it. Every
  // pass of the loop makes exactly one assignment to ready and then waits.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int burst;
    forever begin
      if (sink_hold_cycles > 0) begin
        burst = sink_hold_cycles;
        sink_hold_cycles = 0;
        res_if.ready <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 16);
        res_if.ready <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog. Ends the run if no word moves on either channel for too long.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Offers one byte and returns at the edge where it was taken, or after a random
  // gap in which valid is low. Otherwise valid stays high into the next byte.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (rx_if.ready !== 1'b1);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sends a whole frame: start byte, length, two command bytes, payload and
  // the check byte, which is spoiled when corrupt is set.
  task automatic send_frame(input logic [ByteW-1:0] len, input bit corrupt,
                            input fill_e fill);
    logic [ByteW-1:0] c0;
    logic [ByteW-1:0] c1;
    logic [ByteW-1:0] pb;
    logic [ByteW-1:0] chk;
    c0 = 8'($urandom_range(0, 255));
    c1 = 8'($urandom_range(0, 255));
    if (fill == FILL_SOF) begin
      c0 = cur_sof;
      c1 = cur_sof;
    end else if (fill == FILL_EXTREME) begin
      c0 = 8'h00;
      c1 = 8'hff;
    end
    send_byte(cur_sof);
    send_byte(len);
    send_byte(c0);
    send_byte(c1);
    chk = len ^ c0 ^ c1;
    for (int i = 0; i < int'(len); i++) begin
      case (fill)
        FILL_SOF:     pb = cur_sof;
        FILL_EXTREME: pb = i[0] ? 8'hff : 8'h00;
        default:      pb = 8'($urandom_range(0, 255));
      endcase
      send_byte(pb);
      chk = chk ^ pb;
    end
    if (corrupt) begin
      chk = chk ^ 8'($urandom_range(1, 255));
    end
    send_byte(chk);
    framed_bytes += int'(len) + 5;
  endtask

  // Waits until the block has nothing in flight: input idle, every expected
  // word delivered, and a further wait so bytes that produce no word also leave the block.
  task automatic settle();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (WordLatency + 2) @(posedge clk_i);
  endtask

  // Writes the start byte register. Only called right after settle.
  task automatic write_sof(input logic [ByteW-1:0] v);
    sof_byte_we_i <= 1'b1;
    sof_byte_i    <= v;
    @(posedge clk_i);
    sof_byte_we_i <= 1'b0;
    cur_sof = v;
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Reset start byte: stray bytes are dropped while hunting, then a frame
  // with no payload and a frame with a spoiled check at the byte extremes.
  task automatic test_hunt_and_basic();
    send_byte(8'h00);
    send_byte(8'hff);
    send_frame(8'd0, 1'b0, FILL_RANDOM);
    send_frame(8'd2, 1'b1, FILL_EXTREME);
  endtask

  // The start byte changes after the length byte of a frame. The frame must
  // finish with its old framing, the old start byte is then just noise, and
  // the next frame opens on the new value. That frame carries the start
  // byte as length, command bytes and check, which is plain data there.
  task automatic test_sof_change_mid_frame();
    settle();
    send_byte(cur_sof);
    send_byte(8'd1);
    settle();
    write_sof(8'h00);
    send_byte(SofReset);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'd1 ^ SofReset);
    send_byte(SofReset);
    send_frame(8'd0, 1'b0, FILL_SOF);
  endtask

  // The receiver holds off long enough for the output and input registers
  // to fill, so the block has to stall its input while bytes keep coming.
  task automatic test_output_hold_off();
    bit keep_idle;
    keep_idle = idle_en;
    settle();
    idle_en = 1'b0;
    sink_hold_cycles = HoldOffCycles;
    repeat (8) send_frame(8'($urandom_range(0, 12)), $urandom_range(0, 3) == 0,
                          FILL_RANDOM);
    idle_en = keep_idle;
  endtask

  // Random traffic under one start byte setting. Most of it is complete
  // frames with random content, some with a spoiled check and a few long ones
  // of 200 to 255 bytes; the rest is loose bytes and frames cut short, which
  // throw the framing off until the block finds its way back.
  task automatic test_random_frames(input logic [ByteW-1:0] sof, input int n_bytes,
                                    input bit with_longest);
    int target;
    int pick;
    int cut;
    logic [ByteW-1:0] len;
    settle();
    write_sof(sof);
    target = framed_bytes + n_bytes;
    if (with_longest) begin
      send_frame(8'd255, 1'b0, FILL_RANDOM);
    end
    while (framed_bytes < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 14) begin
        len = 8'($urandom_range(1, 12));
        cut = $urandom_range(0, int'(len) + 1);
        send_byte(cur_sof);
        send_byte(len);
        repeat (cut) send_byte(8'($urandom_range(0, 255)));
        framed_bytes += cut + 2;
      end else begin
        if ($urandom_range(0, 59) == 0) begin
          len = 8'($urandom_range(200, 255));
        end else begin
          len = 8'($urandom_range(0, 12));
        end
        send_frame(len, $urandom_range(0, 4) == 0, FILL_RANDOM);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence. Reset once, then the tests in turn; the last phase runs with
  // no idling on either channel.
  // --------------------------------------------------------------------------
  initial begin : run_tests
    rst_ni        <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    sof_byte_we_i <= 1'b0;
    sof_byte_i    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_hunt_and_basic();
    test_sof_change_mid_frame();
    test_output_hold_off();
    test_random_frames(8'hff, 500, 1'b1);
    test_random_frames(8'($urandom_range(0, 255)), 500, 1'b0);
    idle_en = 1'b0;
    test_random_frames(SofReset, 400, 1'b0);
    settle();

    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sofdf_pkg.sv
hw/rtl/sofdf_if.sv
hw/rtl/sofdf_core.sv
hw/rtl/sof_length_xor_frame_deframer.sv
test/tb_sof_length_xor_frame_deframer.sv
